// File: src/mbsp_pkg.sv
// Package for the MIDI byte stream parser: event codes, MIDI status constants,
// the result record and the data length lookup. No dependencies.
`timescale 1ns / 1ps

package mbsp_pkg;

   localparam int SYSEX_LIMIT_DEFAULT = 128;

   localparam logic [7:0] STATUS_REALTIME_MIN = 8'hF8;
   localparam logic [7:0] STATUS_SYSTEM_MIN   = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX_START  = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX_END    = 8'hF7;
   localparam logic [7:0] STATUS_SONG_POS     = 8'hF2;
   localparam logic [7:0] STATUS_MTC_QFRAME   = 8'hF1;
   localparam logic [7:0] STATUS_SONG_SELECT  = 8'hF3;
   localparam logic [7:0] STATUS_TUNE_REQUEST = 8'hF6;
   localparam logic [7:0] STATUS_SYSTEM_RESET = 8'hFF;
   localparam logic [7:0] STATUS_NOTE_OFF     = 8'h80;
   localparam logic [7:0] STATUS_NOTE_ON      = 8'h90;
   localparam logic [3:0] NIBBLE_PROG_CHANGE  = 4'hC;
   localparam logic [3:0] NIBBLE_CHAN_PRESS   = 4'hD;
   localparam logic [7:0] CHANNEL_MASK        = 8'h0F;

   typedef enum logic [1:0] {
      KIND_MESSAGE     = 2'd0,
      KIND_REALTIME    = 2'd1,
      KIND_SYSEX_DATA  = 2'd2,
      KIND_SYSEX_END   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    event_kind;
      logic [7:0]  status_code;
      logic [4:0]  channel_number;
      logic [6:0]  first_data;
      logic [6:0]  second_data;
      logic [13:0] combined_value;
      logic [7:0]  sysex_count;
   } result_type;

   // number of data bytes that follow a (normalized) status
   function automatic logic [1:0] data_length(input logic [7:0] st);
      logic [1:0] len;
      len = 2'd0;
      if (st < STATUS_SYSTEM_MIN) begin
         if (st[7:4] == NIBBLE_PROG_CHANGE || st[7:4] == NIBBLE_CHAN_PRESS) begin
            len = 2'd1;
         end else begin
            len = 2'd2;
         end
      end else if (st == STATUS_MTC_QFRAME || st == STATUS_SONG_SELECT) begin
         len = 2'd1;
      end else if (st == STATUS_SONG_POS) begin
         len = 2'd2;
      end
      return len;
   endfunction

endpackage

// File: src/mbsp_if.sv
// Channel interfaces of the MIDI byte stream parser: byte input, result output
// and configuration write. Depends on nothing.
`timescale 1ns / 1ps

interface mbsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] midi_byte;
   modport source (output valid, output midi_byte, input ready);
   modport sink (input valid, input midi_byte, output ready);
endinterface

interface mbsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [7:0]  status_code;
   logic [4:0]  channel_number;
   logic [6:0]  first_data;
   logic [6:0]  second_data;
   logic [13:0] combined_value;
   logic [7:0]  sysex_count;
   modport source (output valid, output event_kind, output status_code,
                   output channel_number, output first_data, output second_data,
                   output combined_value, output sysex_count, input ready);
   modport sink (input valid, input event_kind, input status_code,
                 input channel_number, input first_data, input second_data,
                 input combined_value, input sysex_count, output ready);
endinterface

interface mbsp_csr_if;
   logic valid;
   logic ready;
   logic raw_mode;
   modport source (output valid, output raw_mode, input ready);
   modport sink (input valid, input raw_mode, output ready);
endinterface

// File: src/mbsp_core.sv
// Parser state (running status, channel, counts, held data) and the per-byte
// decode that forms the result record. Depends on mbsp_pkg.
`timescale 1ns / 1ps

module mbsp_core #(
   parameter int SYSEX_LIMIT = mbsp_pkg::SYSEX_LIMIT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             midi_byte,
   input  logic                   raw_mode,
   output logic                   emit,
   output mbsp_pkg::result_type   result
);
   import mbsp_pkg::*;

   localparam logic [7:0] LIMIT = 8'(SYSEX_LIMIT);

   logic       status_valid_ff, status_valid_in;
   logic [7:0] status_ff, status_in;
   logic [4:0] channel_ff, channel_in;
   logic [1:0] expected_ff, expected_in;
   logic [7:0] count_ff, count_in;
   logic [6:0] held0_ff, held0_in;
   logic [6:0] held1_ff, held1_in;

   logic [7:0] new_status;
   logic [1:0] new_len;
   logic [7:0] count_inc;
   logic [6:0] d0;
   logic [6:0] d1;
   logic [7:0] msg_status;

   always_comb begin
      new_status = (midi_byte >= STATUS_SYSTEM_MIN) ? midi_byte : {midi_byte[7:4], 4'h0};
      new_len    = data_length(new_status);
      count_inc  = count_ff + 8'd1;
      // held data as it stands after this byte is written
      d0 = (count_ff[0] == 1'b0) ? midi_byte[6:0] : held0_ff;
      d1 = (expected_ff == 2'd2) ? ((count_ff[0] == 1'b1) ? midi_byte[6:0] : held1_ff)
                                 : 7'd0;
      msg_status = status_ff;
      if (!raw_mode && status_ff == STATUS_NOTE_ON && d1 == 7'd0) begin
         msg_status = STATUS_NOTE_OFF;
      end
   end

   always_comb begin
      status_valid_in = status_valid_ff;
      status_in       = status_ff;
      channel_in      = channel_ff;
      expected_in     = expected_ff;
      count_in        = count_ff;
      held0_in        = held0_ff;
      held1_in        = held1_ff;
      emit            = 1'b0;
      result          = '0;

      priority if (midi_byte >= STATUS_REALTIME_MIN) begin
         if (raw_mode) begin
            emit               = 1'b1;
            result.event_kind  = KIND_REALTIME;
            result.status_code = midi_byte;
         end else if (midi_byte == STATUS_SYSTEM_RESET) begin
            status_valid_in = 1'b0;
            status_in       = 8'd0;
            channel_in      = 5'd0;
            expected_in     = 2'd0;
            count_in        = 8'd0;
         end
      end else if (midi_byte == STATUS_SYSEX_END) begin
         if (status_valid_ff && status_ff == STATUS_SYSEX_START && raw_mode) begin
            emit               = 1'b1;
            result.event_kind  = KIND_SYSEX_END;
            result.status_code = STATUS_SYSEX_END;
            result.sysex_count = count_ff;
         end
         status_valid_in = 1'b0;
         count_in        = 8'd0;
      end else if (midi_byte[7]) begin
         count_in    = 8'd0;
         status_in   = new_status;
         channel_in  = (midi_byte < STATUS_SYSTEM_MIN) ?
                       {1'b0, (midi_byte[3:0] & CHANNEL_MASK[3:0])} + 5'd1 : 5'd0;
         expected_in = new_len;
         // zero-length statuses other than sysex start leave no running status
         status_valid_in = !(new_len == 2'd0 && new_status != STATUS_SYSEX_START);
         if (new_status == STATUS_TUNE_REQUEST && raw_mode) begin
            emit               = 1'b1;
            result.event_kind  = KIND_MESSAGE;
            result.status_code = STATUS_TUNE_REQUEST;
         end
      end else if (!status_valid_ff) begin
         // data without status: dropped
      end else if (status_ff == STATUS_SYSEX_START) begin
         if (count_ff < LIMIT) begin
            count_in = count_inc;
            if (raw_mode) begin
               emit               = 1'b1;
               result.event_kind  = KIND_SYSEX_DATA;
               result.status_code = STATUS_SYSEX_START;
               result.first_data  = midi_byte[6:0];
            end
         end
      end else begin
         if (count_ff[0] == 1'b0) begin
            held0_in = midi_byte[6:0];
         end else begin
            held1_in = midi_byte[6:0];
         end
         if (count_inc < {6'd0, expected_ff}) begin
            count_in = count_inc;
         end else begin
            count_in = 8'd0;
            if (raw_mode || status_ff < STATUS_SYSTEM_MIN) begin
               emit                  = 1'b1;
               result.event_kind     = KIND_MESSAGE;
               result.status_code    = msg_status;
               result.channel_number = channel_ff;
               result.first_data     = d0;
               result.second_data    = d1;
               result.combined_value = {d1, d0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_valid_ff <= 1'b0;
         status_ff       <= 8'd0;
         channel_ff      <= 5'd0;
         expected_ff     <= 2'd0;
         count_ff        <= 8'd0;
         held0_ff        <= 7'd0;
         held1_ff        <= 7'd0;
      end else if (step) begin
         status_valid_ff <= status_valid_in;
         status_ff       <= status_in;
         channel_ff      <= channel_in;
         expected_ff     <= expected_in;
         count_ff        <= count_in;
         held0_ff        <= held0_in;
         held1_ff        <= held1_in;
      end
   end

endmodule

// File: src/mbsp_out_reg.sv
// Result register of the MIDI byte stream parser: holds one result until the
// sink takes it. Depends on mbsp_pkg.
`timescale 1ns / 1ps

module mbsp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 load_valid,
   input  mbsp_pkg::result_type load_data,
   output logic                 can_load,
   mbsp_rsp_if.source           rsp_chan
);
   import mbsp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = load_valid;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.event_kind     = data_ff.event_kind;
   assign rsp_chan.status_code    = data_ff.status_code;
   assign rsp_chan.channel_number = data_ff.channel_number;
   assign rsp_chan.first_data     = data_ff.first_data;
   assign rsp_chan.second_data    = data_ff.second_data;
   assign rsp_chan.combined_value = data_ff.combined_value;
   assign rsp_chan.sysex_count    = data_ff.sysex_count;

endmodule

// File: src/midi_byte_stream_parser_unit.sv
// Top level of the MIDI byte stream parser: input byte register, raw_mode
// register, parser core and result register. Depends on mbsp_pkg, mbsp_if,
// mbsp_core and mbsp_out_reg.
//
//   channel   | direction | payload
//   ----------+-----------+-----------------------------------------------
//   req_chan  | in        | midi_byte
//   rsp_chan  | out       | event_kind, status_code, channel_number,
//             |           | first_data, second_data, combined_value,
//             |           | sysex_count
//   csr_chan  | in        | raw_mode (always ready)
//
// One byte per cycle sustained while the sink takes results; a byte held
// in the input register goes into the result register as it advances, and its
// result is offered there. Bytes that give no result leave that register empty.
// Synchronous reset clears the parser state, raw_mode and both valid flags.
// A stalled result blocks the decode step; the input register still takes a
// transaction while it is empty or advancing.
`timescale 1ns / 1ps

module midi_byte_stream_parser_unit #(
   parameter int SYSEX_LIMIT = mbsp_pkg::SYSEX_LIMIT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mbsp_csr_if.sink   csr_chan,
   mbsp_req_if.sink   req_chan,
   mbsp_rsp_if.source rsp_chan
);
   import mbsp_pkg::*;

   logic       raw_mode_ff;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       can_load;
   logic       emit;
   result_type result;

   assign csr_chan.ready = 1'b1;
   assign advance        = in_valid_ff && can_load;
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff <= 1'b0;
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_chan.valid) begin
            raw_mode_ff <= csr_chan.raw_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.midi_byte;
      end
   end

   mbsp_core #(
      .SYSEX_LIMIT (SYSEX_LIMIT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .midi_byte (in_byte_ff),
      .raw_mode  (raw_mode_ff),
      .emit      (emit),
      .result    (result)
   );

   mbsp_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (emit),
      .load_data  (result),
      .can_load   (can_load),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: bench/mbsp_event_checker.sv
`timescale 1ns / 1ps
// Result checker for midi_byte_stream_parser_unit: watches the byte, result and
// csr channels, predicts each result and compares it. Depends on mbsp_pkg, mbsp_if.

module mbsp_event_checker #(
   parameter int SYSEX_LIMIT = mbsp_pkg::SYSEX_LIMIT_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   mbsp_req_if  req_mon,
   mbsp_rsp_if  rsp_mon,
   mbsp_csr_if  csr_mon,
   output int   error_count,
   output int   expected_pending,
   output int   results_checked
);
   import mbsp_pkg::*;

   // predicted parser state
   logic       mode_raw;
   logic       run_valid;
   logic [7:0] run_status;
   logic [4:0] run_channel;
   logic [1:0] data_needed;
   logic [7:0] data_seen;
   logic [6:0] held_data [2];

   result_type midi_expected_q [$];
   result_type oldest;

   function automatic logic [1:0] msg_data_bytes(input logic [7:0] st);
      logic [1:0] n;
      case (st[7:4])
         NIBBLE_PROG_CHANGE, NIBBLE_CHAN_PRESS: n = 2'd1;
         4'hF: begin
            case (st)
               STATUS_MTC_QFRAME, STATUS_SONG_SELECT: n = 2'd1;
               STATUS_SONG_POS:                       n = 2'd2;
               default:                               n = 2'd0;
            endcase
         end
         default: n = 2'd2;
      endcase
      return n;
   endfunction

   task automatic clear_parse_state();
      run_valid   = 1'b0;
      run_status  = '0;
      run_channel = '0;
      data_needed = '0;
      data_seen   = '0;
   endtask

   task automatic parse_midi_byte(input logic [7:0] b);
      result_type ev;
      bit         emit;
      logic [7:0] st;
      logic [6:0] d0;
      logic [6:0] d1;
      ev   = '0;
      emit = 1'b0;
      if (b >= STATUS_REALTIME_MIN) begin
         if (mode_raw) begin
            ev.event_kind  = KIND_REALTIME;
            ev.status_code = b;
            emit = 1'b1;
         end else if (b == STATUS_SYSTEM_RESET) begin
            clear_parse_state();
         end
      end else if (b[7]) begin
         if (b == STATUS_SYSEX_END) begin
            if (run_valid && run_status == STATUS_SYSEX_START && mode_raw) begin
               ev.event_kind  = KIND_SYSEX_END;
               ev.status_code = STATUS_SYSEX_END;
               ev.sysex_count = data_seen;
               emit = 1'b1;
            end
            run_valid = 1'b0;
            data_seen = '0;
         end else begin
            data_seen   = '0;
            run_status  = (b >= STATUS_SYSTEM_MIN) ? b : {b[7:4], 4'h0};
            run_channel = (b < STATUS_SYSTEM_MIN) ? 5'(b[3:0]) + 5'd1 : 5'd0;
            data_needed = msg_data_bytes(run_status);
            run_valid   = 1'b1;
            // zero-length statuses other than sysex start leave no running status behind
            if (data_needed == 2'd0 && run_status != STATUS_SYSEX_START) begin
               run_valid = 1'b0;
               if (run_status == STATUS_TUNE_REQUEST && mode_raw) begin
                  ev.event_kind  = KIND_MESSAGE;
                  ev.status_code = STATUS_TUNE_REQUEST;
                  emit = 1'b1;
               end
            end
         end
      end else if (run_valid) begin
         if (run_status == STATUS_SYSEX_START) begin
            if (data_seen < SYSEX_LIMIT) begin
               data_seen++;
               if (mode_raw) begin
                  ev.event_kind  = KIND_SYSEX_DATA;
                  ev.status_code = STATUS_SYSEX_START;
                  ev.first_data  = b[6:0];
                  emit = 1'b1;
               end
            end
         end else begin
            held_data[data_seen[0]] = b[6:0];
            data_seen++;
            if (data_seen >= 8'(data_needed)) begin
               data_seen = '0;
               st = run_status;
               d0 = held_data[0];
               d1 = (data_needed == 2'd2) ? held_data[1] : 7'd0;
               if (mode_raw || st < STATUS_SYSTEM_MIN) begin
                  if (!mode_raw && st == STATUS_NOTE_ON && d1 == 7'd0) st = STATUS_NOTE_OFF;
                  ev.event_kind     = KIND_MESSAGE;
                  ev.status_code    = st;
                  ev.channel_number = run_channel;
                  ev.first_data     = d0;
                  ev.second_data    = d1;
                  ev.combined_value = {d1, d0};
                  emit = 1'b1;
               end
            end
         end
      end
      if (emit) midi_expected_q.push_back(ev);
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_raw     = 1'b0;
         held_data[0] = '0;
         held_data[1] = '0;
         clear_parse_state();
         midi_expected_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) mode_raw = csr_mon.raw_mode;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (midi_expected_q.size() == 0) begin
               error_count++;
               $display("%0t ns: unexpected result, expected none, actual kind %0d status 0x%0h",
                        $time, rsp_mon.event_kind, rsp_mon.status_code);
            end else begin
               oldest = midi_expected_q.pop_front();
               check_field("event_kind", 16'(oldest.event_kind), 16'(rsp_mon.event_kind));
               check_field("status_code", 16'(oldest.status_code), 16'(rsp_mon.status_code));
               check_field("channel_number", 16'(oldest.channel_number),
                           16'(rsp_mon.channel_number));
               check_field("first_data", 16'(oldest.first_data), 16'(rsp_mon.first_data));
               check_field("second_data", 16'(oldest.second_data), 16'(rsp_mon.second_data));
               check_field("combined_value", 16'(oldest.combined_value),
                           16'(rsp_mon.combined_value));
               check_field("sysex_count", 16'(oldest.sysex_count), 16'(rsp_mon.sysex_count));
               results_checked++;
            end
         end
         if (req_mon.valid && req_mon.ready) parse_midi_byte(req_mon.midi_byte);
      end
      expected_pending = midi_expected_q.size();
   end

endmodule

// File: bench/tb_midi_byte_stream_parser_unit.sv
`timescale 1ns / 1ps
// Top of the bench for midi_byte_stream_parser_unit: clock, reset, byte stimulus,
// result back-pressure, watchdog and verdict. Depends on mbsp_pkg, mbsp_if, mbsp_event_checker.

module tb_midi_byte_stream_parser_unit;
   import mbsp_pkg::*;

   localparam int IDLE_LIMIT       = 4000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int PHASE_BYTES      = 80;
   localparam int PHASE_COUNT      = 5;

   localparam logic [7:0] UNDEF_COMMON_F4   = 8'hF4;
   localparam logic [7:0] UNDEF_COMMON_F5   = 8'hF5;
   localparam logic [7:0] UNDEF_REALTIME_F9 = 8'hF9;
   localparam logic [7:0] UNDEF_REALTIME_FD = 8'hFD;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   no_idle = 1'b0;
   bit   hold_request = 1'b0;
   bit   inject_realtime = 1'b0;
   int   bytes_sent = 0;
   int   mode_writes = 0;
   int   idle_cycles = 0;
   int   mismatch_total;
   int   results_waiting;
   int   results_seen;

   mbsp_req_if req_chan ();
   mbsp_rsp_if rsp_chan ();
   mbsp_csr_if csr_chan ();

   always #5 clock = ~clock;

   midi_byte_stream_parser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mbsp_event_checker u_event_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_mon          (csr_chan),
      .error_count      (mismatch_total),
      .expected_pending (results_waiting),
      .results_checked  (results_seen)
   );

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.midi_byte <= b;
      do begin
         @(posedge clock);
      end while (!(req_chan.valid && req_chan.ready));
      bytes_sent++;
   endtask

   function automatic logic [6:0] pick_data();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 7'h00;
      if (r == 1) return 7'h7F;
      return 7'($urandom_range(0, 127));
   endfunction

   // realtime bytes may land anywhere in the stream
   task automatic send_midi(input logic [7:0] b);
      if (inject_realtime && $urandom_range(0, 24) == 0) begin
         send_byte(8'($urandom_range(int'(STATUS_REALTIME_MIN), 255)));
      end
      send_byte(b);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      settle();
      csr_chan.valid    <= 1'b1;
      csr_chan.raw_mode <= mode;
      do begin
         @(posedge clock);
      end while (!(csr_chan.valid && csr_chan.ready));
      csr_chan.valid <= 1'b0;
      mode_writes++;
   endtask

   task automatic send_sysex(input int payload, input bit terminate);
      send_midi(STATUS_SYSEX_START);
      repeat (payload) send_midi({1'b0, pick_data()});
      if (terminate) send_midi(STATUS_SYSEX_END);
   endtask

   task automatic send_random_message();
      int         pick;
      int         reps;
      int         len;
      int         payload;
      logic [7:0] st;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         st   = 8'h80 + 8'($urandom_range(0, 111));
         len  = (st[7:4] == NIBBLE_PROG_CHANGE || st[7:4] == NIBBLE_CHAN_PRESS) ? 1 : 2;
         reps = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 5) : 1;
         send_midi(st);
         repeat (reps) begin
            repeat (len) send_midi({1'b0, pick_data()});
         end
      end else if (pick < 65) begin
         // system common 0xF1..0xF6, followed by up to two data bytes
         st = STATUS_MTC_QFRAME + 8'($urandom_range(0, 5));
         send_midi(st);
         repeat ($urandom_range(0, 2)) send_midi({1'b0, pick_data()});
      end else if (pick < 75) begin
         payload = ($urandom_range(0, 9) == 0) ? $urandom_range(126, 140)
                                               : $urandom_range(0, 10);
         send_sysex(payload, $urandom_range(0, 4) != 0);
      end else if (pick < 83) begin
         send_byte(8'($urandom_range(int'(STATUS_REALTIME_MIN), 255)));
      end else if (pick < 91) begin
         send_byte({1'b0, 7'($urandom)});
      end else if (pick < 94) begin
         send_byte(STATUS_SYSEX_END);
      end else begin
         // partial message cut short by another status
         send_midi(8'h80 + 8'($urandom_range(0, 111)));
         send_midi({1'b0, pick_data()});
         send_midi(8'($urandom_range(128, int'(STATUS_REALTIME_MIN) - 1)));
      end
   endtask

   // result side: random hold-off per transaction, one long hold on request
   initial begin : result_sink
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 16);
         if (hold_request) begin
            hold_request = 1'b0;
            gap += LONG_HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: watchdog expired with %0d results outstanding",
                  $time, results_waiting);
         $display("midi_byte_stream_parser_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int phase_end;
      logic [7:0] plain_seq [17];
      logic [7:0] raw_seq [22];
      // default mode: orphan data, note-on then velocity-0 note-off by running
      // status, program change, pitch bend top, filtered system bytes, reset
      plain_seq = '{8'h45, STATUS_NOTE_ON, 8'h3C, 8'h64, 8'h3C, 8'h00, 8'hC5, 8'h7F,
                    8'hEF, 8'h7F, 8'h7F, STATUS_REALTIME_MIN, STATUS_SONG_POS, 8'h01,
                    8'h02, STATUS_SYSTEM_RESET, 8'h40};
      // raw mode: sysex, stray end, undefined common, tune request, realtime,
      // pitch bend zero, sysex cut short by a channel message
      raw_seq = '{STATUS_SYSEX_START, 8'h00, 8'h7F, STATUS_SYSEX_END, STATUS_SYSEX_END,
                  UNDEF_COMMON_F5, 8'h12, STATUS_TUNE_REQUEST, STATUS_MTC_QFRAME, 8'h11,
                  UNDEF_REALTIME_F9, UNDEF_REALTIME_FD, STATUS_SYSTEM_RESET, 8'hA3, 8'h01,
                  8'hE0, 8'h00, 8'h00, STATUS_SYSEX_START, 8'h01, 8'hD2, 8'h55};
      req_chan.valid     <= 1'b0;
      req_chan.midi_byte <= 8'h00;
      csr_chan.valid     <= 1'b0;
      csr_chan.raw_mode  <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      write_mode(1'b0);
      foreach (plain_seq[i]) send_byte(plain_seq[i]);
      write_mode(1'b1);
      foreach (raw_seq[i]) send_byte(raw_seq[i]);
      send_byte(UNDEF_COMMON_F4);
      send_byte(8'h33);

      inject_realtime = 1'b1;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         write_mode(phase % 2 == 0);
         no_idle = (phase == 2);
         if (phase == 0) begin
            send_sysex(SYSEX_LIMIT_DEFAULT + 7, 1'b1);
            // back-pressure: results pile up while bytes keep coming
            no_idle      = 1'b1;
            hold_request = 1'b1;
            send_sysex(40, 1'b1);
            no_idle = 1'b0;
         end
         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end) send_random_message();
      end
      no_idle = 1'b0;
      settle();

      $display("Run covered %0d MIDI bytes under %0d mode writes; %0d results compared.",
               bytes_sent, mode_writes, results_seen);
      if (mismatch_total == 0) begin
         $display("midi_byte_stream_parser_unit verification clean");
      end else begin
         $display("midi_byte_stream_parser_unit verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
src/mbsp_pkg.sv
src/mbsp_if.sv
src/mbsp_core.sv
src/mbsp_out_reg.sv
src/midi_byte_stream_parser_unit.sv
bench/mbsp_event_checker.sv
bench/tb_midi_byte_stream_parser_unit.sv
